/* sv/qpl_pkg.sv */
package qpl_pkg;

    // quartic kernel, weights over 2^KERN_SHIFT, oldest tap first
    localparam int NTAPS = 5;
    localparam int KERN_LEFT  [NTAPS] = '{-45, 420, 1890, -252, 35};
    localparam int KERN_RIGHT [NTAPS] = '{35, -252, 1890, 420, -45};
    localparam int KERN_SHIFT = 11;
    localparam int KERN_ROUND = 1 << (KERN_SHIFT - 1);

    // limiter slope is carried in units of 2^-LIM_SHIFT
    localparam int LIM_SHIFT = 14;
    localparam int LIM_ROUND = 1 << (LIM_SHIFT - 1);

    // stored window and its fill count
    localparam int WIN_TAPS = NTAPS - 1;
    localparam int FILL_BITS = 3;
    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WIN_TAPS);

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // configuration
    localparam int COEFF_BITS = 16;
    localparam logic [COEFF_BITS-1:0] COEFF_RESET = 16'd8192;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MONO_EN    = 1'b0,
        CFG_MONO_COEFF = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                  mono_en;
        logic [COEFF_BITS-1:0] coeff;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

/* sv/qpl_front.sv */
module qpl_front #(
    parameter int S = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [S-1:0]                i_sample,
    input  logic                        i_row_start,
    input  logic                        i_space,
    output logic                        o_ready,
    output logic                        o_push,
    output logic [qpl_pkg::NTAPS*S-1:0] o_entry
);
    import qpl_pkg::*;

    logic [S-1:0]           r_win [WIN_TAPS];
    logic [FILL_BITS-1:0]   r_fill;
    logic [FILL_BITS-1:0]   n_fill;
    logic                   w_accept;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;
    // a row start discards whatever the window held
    assign o_push   = w_accept && !i_row_start && (r_fill == FILL_FULL);

    always_comb begin
        for (int i = 0; i < WIN_TAPS; i++) begin
            o_entry[i*S +: S] = r_win[i];
        end
        o_entry[WIN_TAPS*S +: S] = i_sample;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            if (i_row_start) begin
                n_fill = FILL_BITS'(1);
            end else if (r_fill != FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < WIN_TAPS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_TAPS-1] <= i_sample;
        end
    end

endmodule

/* sv/qpl_queue.sv */
module qpl_queue #(
    parameter int WIDTH = 160
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output qpl_pkg::t_q_flags o_flags
);
    import qpl_pkg::*;

    logic [WIDTH-1:0]     r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic [QPTR_BITS-1:0] n_wr;
    logic [QPTR_BITS-1:0] n_rd;
    logic [QCNT_BITS-1:0] n_cnt;

    assign o_flags.full  = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_flags.empty = (r_cnt == '0);
    assign o_data        = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_BITS'(QDEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

endmodule

/* sv/qpl_back.sv */
module qpl_back #(
    parameter int S = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qpl_pkg::t_cfg               i_cfg,
    input  logic                        i_q_valid,
    input  logic [qpl_pkg::NTAPS*S-1:0] i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [S-1:0]                o_fine_left,
    output logic [S-1:0]                o_fine_right,
    output logic                        o_limited
);
    import qpl_pkg::*;

    localparam int PW  = S + 13;              // exact kernel sums
    localparam int PRW = PW - KERN_SHIFT;     // rounded kernel values
    localparam int DW  = S + 1;               // sample differences
    localparam int AW  = DW + COEFF_BITS;     // slope candidates
    localparam int LW  = AW + 2;              // limiter sums
    localparam int RW  = LW - LIM_SHIFT;      // final values before saturation

    function automatic logic [S-1:0] sat(input logic signed [RW-1:0] v);
        logic [RW-S:0] hi_bits;
        hi_bits = v[RW-1:S-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return v[S-1:0];
        end else if (v[RW-1]) begin
            return {1'b1, {(S-1){1'b0}}};
        end else begin
            return {1'b0, {(S-1){1'b1}}};
        end
    endfunction

    logic w_adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign w_adv   = !r_v5 || i_ready;
    assign o_pop   = w_adv && i_q_valid;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: kernel sums and slopes
    logic signed [S-1:0]  w1_s [NTAPS];
    logic signed [PW-1:0] w1_pl, w1_pr;

    always_comb begin
        w1_pl = '0;
        w1_pr = '0;
        for (int i = 0; i < NTAPS; i++) begin
            w1_s[i] = $signed(i_entry[i*S +: S]);
            w1_pl = w1_pl + PW'(w1_s[i]) * PW'(KERN_LEFT[i]);
            w1_pr = w1_pr + PW'(w1_s[i]) * PW'(KERN_RIGHT[i]);
        end
    end

    logic signed [PW-1:0] r1_pl, r1_pr;
    logic signed [S-1:0]  r1_l1, r1_c, r1_r1;
    logic signed [DW-1:0] r1_dl, r1_dr, r1_drl;

    // stage 2: rounding, limiter tests, slope magnitudes
    logic signed [PRW-1:0] w2_fl, w2_fr;
    logic signed [PW-1:0]  w2_cmax, w2_cmin;
    logic                  w2_posl, w2_negl, w2_posr, w2_negr;
    logic                  w2_agree, w2_outside, w2_rev;
    logic [DW-1:0]         w2_adl, w2_adr, w2_arl;

    always_comb begin
        w2_fl   = PRW'((r1_pl + PW'(KERN_ROUND)) >>> KERN_SHIFT);
        w2_fr   = PRW'((r1_pr + PW'(KERN_ROUND)) >>> KERN_SHIFT);
        w2_negl = r1_dl[DW-1];
        w2_posl = !r1_dl[DW-1] && (r1_dl != '0);
        w2_negr = r1_dr[DW-1];
        w2_posr = !r1_dr[DW-1] && (r1_dr != '0);
        w2_agree = (w2_posl && w2_posr) || (w2_negl && w2_negr);
        // bounds of the two neighbours, scaled to kernel units
        w2_cmax = (w2_posl ? PW'(r1_r1) : PW'(r1_l1)) <<< KERN_SHIFT;
        w2_cmin = (w2_posl ? PW'(r1_l1) : PW'(r1_r1)) <<< KERN_SHIFT;
        w2_outside = (r1_pl > w2_cmax) || (r1_pr > w2_cmax)
                  || (r1_pl < w2_cmin) || (r1_pr < w2_cmin);
        w2_rev = (w2_posl && (r1_pr < r1_pl)) || (w2_negl && (r1_pr > r1_pl));
        w2_adl = r1_dl[DW-1]  ? DW'(-r1_dl)  : DW'(r1_dl);
        w2_adr = r1_dr[DW-1]  ? DW'(-r1_dr)  : DW'(r1_dr);
        w2_arl = r1_drl[DW-1] ? DW'(-r1_drl) : DW'(r1_drl);
    end

    logic signed [PRW-1:0] r2_fl, r2_fr;
    logic                  r2_agree, r2_repl, r2_pos;
    logic [DW-1:0]         r2_adl, r2_adr, r2_arl;
    logic signed [S-1:0]   r2_c;

    // stage 3: slope candidates
    logic signed [PRW-1:0] r3_fl, r3_fr;
    logic                  r3_agree, r3_repl, r3_pos;
    logic [AW-1:0]         r3_a, r3_b, r3_m0;
    logic signed [S-1:0]   r3_c;

    // stage 4: smallest candidate
    logic [AW-1:0]         w4_m;

    always_comb begin
        if (r3_a < r3_b) begin
            w4_m = (r3_a < r3_m0) ? r3_a : r3_m0;
        end else begin
            w4_m = (r3_b < r3_m0) ? r3_b : r3_m0;
        end
    end

    logic signed [PRW-1:0] r4_fl, r4_fr;
    logic                  r4_agree, r4_repl, r4_pos;
    logic [AW-1:0]         r4_m;
    logic signed [S-1:0]   r4_c;

    // stage 5: limited values, selection, saturation
    logic signed [LW-1:0] w5_cs, w5_ms, w5_sm, w5_sp;
    logic signed [RW-1:0] w5_lo, w5_hi, w5_l, w5_r;
    logic                 w5_lim;

    always_comb begin
        w5_cs = LW'(r4_c) <<< LIM_SHIFT;
        w5_ms = $signed(LW'(r4_m));
        w5_sm = w5_cs - w5_ms + LW'(LIM_ROUND);
        w5_sp = w5_cs + w5_ms + LW'(LIM_ROUND);
        w5_lo = RW'(w5_sm >>> LIM_SHIFT);
        w5_hi = RW'(w5_sp >>> LIM_SHIFT);
        w5_l   = RW'(r4_fl);
        w5_r   = RW'(r4_fr);
        w5_lim = 1'b0;
        if (i_cfg.mono_en) begin
            if (!r4_agree) begin
                w5_l   = RW'(r4_c);
                w5_r   = RW'(r4_c);
                w5_lim = 1'b1;
            end else if (r4_repl) begin
                w5_l   = r4_pos ? w5_lo : w5_hi;
                w5_r   = r4_pos ? w5_hi : w5_lo;
                w5_lim = 1'b1;
            end
        end
    end

    logic [S-1:0] r5_fl, r5_fr;
    logic         r5_lim;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_pl  <= w1_pl;
            r1_pr  <= w1_pr;
            r1_l1  <= w1_s[1];
            r1_c   <= w1_s[2];
            r1_r1  <= w1_s[3];
            r1_dl  <= DW'(w1_s[2]) - DW'(w1_s[1]);
            r1_dr  <= DW'(w1_s[3]) - DW'(w1_s[2]);
            r1_drl <= DW'(w1_s[3]) - DW'(w1_s[1]);

            r2_fl    <= w2_fl;
            r2_fr    <= w2_fr;
            r2_agree <= w2_agree;
            r2_repl  <= w2_agree && (w2_outside || w2_rev);
            r2_pos   <= w2_posl;
            r2_adl   <= w2_adl;
            r2_adr   <= w2_adr;
            r2_arl   <= w2_arl;
            r2_c     <= r1_c;

            r3_fl    <= r2_fl;
            r3_fr    <= r2_fr;
            r3_agree <= r2_agree;
            r3_repl  <= r2_repl;
            r3_pos   <= r2_pos;
            r3_a     <= AW'(r2_adl) * AW'(i_cfg.coeff);
            r3_b     <= AW'(r2_adr) * AW'(i_cfg.coeff);
            r3_m0    <= AW'(r2_arl) << KERN_SHIFT;
            r3_c     <= r2_c;

            r4_fl    <= r3_fl;
            r4_fr    <= r3_fr;
            r4_agree <= r3_agree;
            r4_repl  <= r3_repl;
            r4_pos   <= r3_pos;
            r4_m     <= w4_m;
            r4_c     <= r3_c;

            r5_fl  <= sat(w5_l);
            r5_fr  <= sat(w5_r);
            r5_lim <= w5_lim;
        end
    end

    assign o_fine_left  = r5_fl;
    assign o_fine_right = r5_fr;
    assign o_limited    = r5_lim;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_adv) |=> r_v1)
        else $error("pipeline stage lost an item during stall");

endmodule

/* sv/quartic_prolongation_limited.sv */
// One 1-D pass of 2x quartic prolongation with an optional slope limiter.
// Coarse samples stream in one request per cycle while o_ready is high;
// after the first four samples of a row every request yields one result
// holding the fine values left and right of the window centre (the third
// of the last five samples) plus a flag telling whether the limiter
// replaced the kernel values. Sustained rate is one request per clock in
// and one result per clock out while neither side stalls; each window
// passes through the window queue and then the arithmetic pipeline. A
// four-entry queue between the window front and the pipeline lets either
// side stall without stalling the other. Configuration must be written
// through a plain write port only while the block is idle; the block does
// not enforce this. Index 0 turns the limiter on and index 1 sets its
// coefficient in unsigned Q2.14.
module quartic_prolongation_limited #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [qpl_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [qpl_pkg::COEFF_BITS-1:0]   i_cfg_data,
    // sample requests
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic                             i_row_start,
    // results
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [SAMPLE_BITS-1:0]           o_fine_left,
    output logic [SAMPLE_BITS-1:0]           o_fine_right,
    output logic                             o_limited
);
    import qpl_pkg::*;

    localparam int EW = NTAPS * SAMPLE_BITS;

    // configuration registers
    logic                  r_mono_en;
    logic [COEFF_BITS-1:0] r_coeff;
    t_cfg                  w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_en <= 1'b0;
            r_coeff   <= COEFF_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MONO_EN:    r_mono_en <= i_cfg_data[0];
                CFG_MONO_COEFF: r_coeff   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign w_cfg.mono_en = r_mono_en;
    assign w_cfg.coeff   = r_coeff;

    // front: window and fill tracking, pushes full windows only
    logic          w_push;
    logic          w_pop;
    logic [EW-1:0] w_push_entry;
    logic [EW-1:0] w_pop_entry;
    t_q_flags      w_qflags;

    qpl_front #(
        .S (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_sample    (i_sample),
        .i_row_start (i_row_start),
        .i_space     (!w_qflags.full),
        .o_ready     (o_ready),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // window queue decoupling front and back
    qpl_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_data  (w_pop_entry),
        .o_flags (w_qflags)
    );

    // back: kernel, limiter and saturation pipeline
    qpl_back #(
        .S (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (!w_qflags.empty),
        .i_entry      (w_pop_entry),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_fine_left  (o_fine_left),
        .o_fine_right (o_fine_right),
        .o_limited    (o_limited)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qflags.full)
        else $error("window pushed into a full queue");

endmodule
